FILE: sv/pixlum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pixlum_pkg;

  localparam int CHANNEL_BITS  = 16;
  localparam int FRACTION_BITS = 8;

  localparam int IN_FIELD_W = 16;
  localparam int MAG_W      = 25;
  localparam int VAL_W      = 24;
  localparam int NUM_W      = 3;
  localparam int NUM_CHAN   = 4;
  localparam int LUMA_CHAN  = 3;

  localparam logic [NUM_W-1:0] NUM_RESET = 3'd4;
  localparam logic [NUM_W-1:0] NUM_MIN   = 3'd1;
  localparam logic [NUM_W-1:0] NUM_MAX   = 3'd4;
  localparam logic [NUM_W-1:0] NUM_ONE   = 3'd1;
  localparam logic [NUM_W-1:0] NUM_TWO   = 3'd2;
  localparam logic [NUM_W-1:0] NUM_THREE = 3'd3;
  localparam logic [NUM_W-1:0] NUM_FOUR  = 3'd4;

  localparam int CW       = CHANNEL_BITS;
  localparam int SQ_W     = 2 * CW + 2;
  localparam int ROOT_W   = CW + 1 + FRACTION_BITS;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SUM_W    = CW + 2;
  localparam int MX_W     = SUM_W + FRACTION_BITS;
  localparam int RECIP_K  = MX_W + 1;
  localparam int PROD_W   = MX_W + RECIP_K;
  localparam int WEIGHT_W = 16;
  localparam int ACC_W    = CW + WEIGHT_W;
  localparam int RND_W    = ACC_W + FRACTION_BITS;
  localparam int Q16_SH   = 16;

  localparam logic [RECIP_K-1:0] RECIP3 =
    RECIP_K'(((64'd1 << RECIP_K) + 64'd2) / 64'd3);

  localparam logic [RND_W-1:0] Q16_HALF = RND_W'(1) << (Q16_SH - 1);

  localparam logic [WEIGHT_W-1:0] W601 [LUMA_CHAN] = '{16'd19595, 16'd38470, 16'd7471};
  localparam logic [WEIGHT_W-1:0] W709 [LUMA_CHAN] = '{16'd13933, 16'd46871, 16'd4732};

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_PAD_W  = OUT_DATA_W - MAG_W - 4 * VAL_W;

  typedef struct packed {
    logic [IN_FIELD_W-1:0] chan_three;
    logic [IN_FIELD_W-1:0] chan_two;
    logic [IN_FIELD_W-1:0] chan_one;
    logic [IN_FIELD_W-1:0] chan_zero;
  } in_data_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [VAL_W-1:0]     luma_average;
    logic [VAL_W-1:0]     luma_relative;
    logic [VAL_W-1:0]     luma_perceived;
    logic [VAL_W-1:0]     mean_all;
    logic [MAG_W-1:0]     magnitude;
  } out_data_t;

  typedef struct packed {
    logic             luma_valid;
    logic [VAL_W-1:0] luma_average;
    logic [VAL_W-1:0] luma_relative;
    logic [VAL_W-1:0] luma_perceived;
    logic [VAL_W-1:0] mean_all;
  } side_t;

endpackage

`default_nettype wire

FILE: sv/pixel_luminance_magnitude_features.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel luminance and magnitude features.
// Input stream (in_*): one pixel per beat, four 16-bit channels in in_tdata.
// Result stream (out_*): one beat per pixel, in input order; out_tdata holds
// magnitude, mean_all and the three luminances, out_tuser the luma_valid flag.
// cfg_wr_en / cfg_wr_data write num_channels (1..4, saturated); write only
// while the block is idle.
// Throughput: one pixel per clock, sustained while the receiver keeps taking results.
// Pipeline: four stages do the multiplies, sums, divide-by-three and rounding;
// 25 stages resolve one bit each of the square root (one compare and subtract
// per stage); the output register behind them drives out_tvalid.
// Reset (rst_n low, synchronous) empties the pipeline and sets num_channels
// to 4.
// Stall: the output register is backed by a one-beat skid register. While the
// receiver stalls the pipeline keeps moving until the skid holds a beat; then
// in_tready drops and the whole pipeline holds. Nothing is lost or repeated.
module pixel_luminance_magnitude_features (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire [pixlum_pkg::NUM_W-1:0]        cfg_wr_data,  // num_channels
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // chan_zero, chan_one, chan_two, chan_three
  input  wire [pixlum_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // magnitude, mean_all, luma_perceived, luma_relative, luma_average, zero pad
  output logic [pixlum_pkg::OUT_DATA_W-1:0]  out_tdata,
  // luma_valid
  output logic                               out_tuser
);
  import pixlum_pkg::*;

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] n_eff;
  logic             pipe_en;

  in_data_t        in_d;
  logic [CW-1:0]   c_sel [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= NUM_RESET;
    end else if (cfg_wr_en) begin
      num_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (num_r < NUM_MIN) begin
      n_eff = NUM_MIN;
    end else if (num_r > NUM_MAX) begin
      n_eff = NUM_MAX;
    end else begin
      n_eff = num_r;
    end
  end

  assign in_d = in_data_t'(in_tdata);

  always_comb begin
    c_sel[0] = in_d.chan_zero[CW-1:0];
    c_sel[1] = in_d.chan_one[CW-1:0];
    c_sel[2] = in_d.chan_two[CW-1:0];
    c_sel[3] = in_d.chan_three[CW-1:0];
  end

  // stage 1: squares, weighted products, plain sums
  logic                v1_r;
  logic [2*CW-1:0]     sq1_r   [NUM_CHAN];
  logic [ACC_W-1:0]    p601_1_r [LUMA_CHAN];
  logic [ACC_W-1:0]    p709_1_r [LUMA_CHAN];
  logic [SUM_W-1:0]    sum1_r;
  logic [SUM_W-1:0]    sum3_1_r;
  logic [NUM_W-1:0]    n1_r;
  logic [2*CW-1:0]     sq1_nxt  [NUM_CHAN];
  logic [SUM_W-1:0]    sum1_nxt;

  always_comb begin
    sum1_nxt = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (NUM_W'(i) < n_eff) begin
        sq1_nxt[i] = (2*CW)'(c_sel[i]) * (2*CW)'(c_sel[i]);
        sum1_nxt   = sum1_nxt + SUM_W'(c_sel[i]);
      end else begin
        sq1_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        sq1_r[i] <= sq1_nxt[i];
      end
      for (int i = 0; i < LUMA_CHAN; i++) begin
        p601_1_r[i] <= ACC_W'(W601[i]) * ACC_W'(c_sel[i]);
        p709_1_r[i] <= ACC_W'(W709[i]) * ACC_W'(c_sel[i]);
      end
      sum1_r   <= sum1_nxt;
      sum3_1_r <= SUM_W'(c_sel[0]) + SUM_W'(c_sel[1]) + SUM_W'(c_sel[2]);
      n1_r     <= n_eff;
    end
  end

  // stage 2: radicand, scaled sums, luma accumulators
  logic             v2_r;
  logic [RAD_W-1:0] rad2_r;
  logic [MX_W-1:0]  mx2_r;
  logic [MX_W-1:0]  ax2_r;
  logic [ACC_W-1:0] acc601_2_r;
  logic [ACC_W-1:0] acc709_2_r;
  logic [NUM_W-1:0] n2_r;
  logic [SQ_W-1:0]  sqsum_nxt;

  assign sqsum_nxt = SQ_W'(sq1_r[0]) + SQ_W'(sq1_r[1]) + SQ_W'(sq1_r[2]) + SQ_W'(sq1_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rad2_r     <= RAD_W'(sqsum_nxt) << (2 * FRACTION_BITS);
      mx2_r      <= (MX_W'(sum1_r) << FRACTION_BITS) + MX_W'(n1_r >> 1);
      ax2_r      <= (MX_W'(sum3_1_r) << FRACTION_BITS) + MX_W'(1);
      acc601_2_r <= p601_1_r[0] + p601_1_r[1] + p601_1_r[2];
      acc709_2_r <= p709_1_r[0] + p709_1_r[1] + p709_1_r[2];
      n2_r       <= n1_r;
    end
  end

  // stage 3: reciprocal multiplies, power-of-two means, Q16 rounding
  logic               v3_r;
  logic [RAD_W-1:0]   rad3_r;
  logic [PROD_W-1:0]  mprod3_r;
  logic [PROD_W-1:0]  aprod3_r;
  logic [MX_W-1:0]    msh3_r;
  logic               mdiv3_r;
  logic               lv3_r;
  logic [CW+FRACTION_BITS-1:0] lp3_r;
  logic [CW+FRACTION_BITS-1:0] lr3_r;
  logic [MX_W-1:0]    msh_nxt;
  logic [RND_W-1:0]   rnd601;
  logic [RND_W-1:0]   rnd709;

  always_comb begin
    unique case (n2_r)
      NUM_ONE:  msh_nxt = mx2_r;
      NUM_TWO:  msh_nxt = mx2_r >> 1;
      NUM_FOUR: msh_nxt = mx2_r >> 2;
      default:  msh_nxt = '0;
    endcase
  end

  assign rnd601 = (RND_W'(acc601_2_r) << FRACTION_BITS) + Q16_HALF;
  assign rnd709 = (RND_W'(acc709_2_r) << FRACTION_BITS) + Q16_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rad3_r   <= rad2_r;
      mprod3_r <= PROD_W'(mx2_r) * PROD_W'(RECIP3);
      aprod3_r <= PROD_W'(ax2_r) * PROD_W'(RECIP3);
      msh3_r   <= msh_nxt;
      mdiv3_r  <= (n2_r == NUM_THREE);
      lv3_r    <= (n2_r >= NUM_THREE);
      lp3_r    <= rnd601[RND_W-1:Q16_SH];
      lr3_r    <= rnd709[RND_W-1:Q16_SH];
    end
  end

  // stage 4: select and gate the side results
  logic             v4_r;
  logic [RAD_W-1:0] rad4_r;
  side_t            sd4_r;
  logic [MX_W-1:0]  mq3;
  logic [MX_W-1:0]  aq3;

  assign mq3 = MX_W'(mprod3_r >> RECIP_K);
  assign aq3 = MX_W'(aprod3_r >> RECIP_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (pipe_en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rad4_r               <= rad3_r;
      sd4_r.mean_all       <= mdiv3_r ? VAL_W'(mq3) : VAL_W'(msh3_r);
      sd4_r.luma_valid     <= lv3_r;
      sd4_r.luma_perceived <= lv3_r ? VAL_W'(lp3_r) : '0;
      sd4_r.luma_relative  <= lv3_r ? VAL_W'(lr3_r) : '0;
      sd4_r.luma_average   <= lv3_r ? VAL_W'(aq3) : '0;
    end
  end

  // square root: one result bit per stage, most significant first
  logic              vs_r   [ROOT_W];
  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             sds_r  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - g;
    logic              v_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             sd_in;
    logic [RAD_W-1:0]  trial;

    if (g == 0) begin : g_first
      assign v_in    = v4_r;
      assign rem_in  = rad4_r;
      assign root_in = '0;
      assign sd_in   = sd4_r;
    end else begin : g_next
      assign v_in    = vs_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign sd_in   = sds_r[g-1];
    end

    assign trial = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[g] <= 1'b0;
      end else if (pipe_en) begin
        vs_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sds_r[g] <= sd_in;
        if (rem_in >= trial) begin
          rem_r[g]  <= rem_in - trial;
          root_r[g] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in;
        end
      end
    end
  end

  // output register with skid
  out_data_t last_d;
  logic      last_user;
  logic      last_v;
  out_data_t out_r;
  logic      out_user_r;
  logic      out_v_r;
  out_data_t skid_r;
  logic      skid_user_r;
  logic      skid_v_r;
  logic      push;
  logic      pop;

  always_comb begin
    last_d.pad            = '0;
    last_d.magnitude      = MAG_W'(root_r[ROOT_W-1]);
    last_d.mean_all       = sds_r[ROOT_W-1].mean_all;
    last_d.luma_perceived = sds_r[ROOT_W-1].luma_perceived;
    last_d.luma_relative  = sds_r[ROOT_W-1].luma_relative;
    last_d.luma_average   = sds_r[ROOT_W-1].luma_average;
  end

  assign last_user = sds_r[ROOT_W-1].luma_valid;
  assign last_v    = vs_r[ROOT_W-1];
  assign pipe_en   = !skid_v_r;
  assign push      = pipe_en && last_v;
  assign pop       = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r      <= skid_r;
        out_user_r <= skid_user_r;
      end else begin
        out_r      <= last_d;
        out_user_r <= last_user;
      end
    end
    if (out_v_r && !pop && push) begin
      skid_r      <= last_d;
      skid_user_r <= last_user;
    end
  end

  assign in_tready  = pipe_en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_r);
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

FILE: sv/pixlum_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pixlum_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [pixlum_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                               out_tuser
);
  import pixlum_pkg::*;

  out_data_t od;
  assign od = out_data_t'(out_tdata);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // input side only backs up once a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with no result waiting");

  // luminances are zero when flagged invalid
  a_luma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      od.luma_perceived == '0 && od.luma_relative == '0 && od.luma_average == '0)
    else $error("luminance nonzero with luma_valid low");

  // the mean never exceeds the magnitude
  a_mean_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> MAG_W'(od.mean_all) <= od.magnitude)
    else $error("mean_all above magnitude");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind pixel_luminance_magnitude_features pixlum_checker u_pixlum_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pixlum_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 60;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 75;

  localparam logic [63:0] K601_R = 64'd19595;
  localparam logic [63:0] K601_G = 64'd38470;
  localparam logic [63:0] K601_B = 64'd7471;
  localparam logic [63:0] K709_R = 64'd13933;
  localparam logic [63:0] K709_G = 64'd46871;
  localparam logic [63:0] K709_B = 64'd4732;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [VAL_W-1:0] mean_all;
    logic [VAL_W-1:0] luma_perceived;
    logic [VAL_W-1:0] luma_relative;
    logic [VAL_W-1:0] luma_average;
    logic             luma_valid;
  } feature_t;

  class feature_checker;
    feature_t       expected_features[$];
    logic [NUM_W-1:0] chan_count_reg;
    int             mismatches;

    function new();
      chan_count_reg = NUM_RESET;
      mismatches     = 0;
    endfunction

    function void set_chan_count(logic [NUM_W-1:0] v);
      chan_count_reg = v;
    endfunction

    function int pending();
      return expected_features.size();
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function feature_t predict_features(in_data_t p);
      logic [63:0] ch [NUM_CHAN];
      logic [63:0] n;
      logic [63:0] sq;
      logic [63:0] total;
      logic [63:0] rgb;
      feature_t f;
      if (chan_count_reg == 0) n = 1;
      else if (chan_count_reg > NUM_MAX) n = 4;
      else n = 64'(chan_count_reg);
      ch[0] = 64'(p.chan_zero);
      ch[1] = 64'(p.chan_one);
      ch[2] = 64'(p.chan_two);
      ch[3] = 64'(p.chan_three);
      sq    = 0;
      total = 0;
      for (int i = 0; i < n; i++) begin
        sq    += ch[i] * ch[i];
        total += ch[i];
      end
      f.magnitude = MAG_W'(floor_sqrt(sq << (2 * FRACTION_BITS)));
      f.mean_all  = VAL_W'(((total << FRACTION_BITS) + (n >> 1)) / n);
      if (n >= 3) begin
        f.luma_perceived = VAL_W'((((K601_R * ch[0] + K601_G * ch[1] + K601_B * ch[2])
                                    << FRACTION_BITS) + 64'd32768) >> 16);
        f.luma_relative  = VAL_W'((((K709_R * ch[0] + K709_G * ch[1] + K709_B * ch[2])
                                    << FRACTION_BITS) + 64'd32768) >> 16);
        rgb = ch[0] + ch[1] + ch[2];
        f.luma_average   = VAL_W'(((rgb << FRACTION_BITS) + 64'd1) / 64'd3);
        f.luma_valid     = 1'b1;
      end else begin
        f.luma_perceived = '0;
        f.luma_relative  = '0;
        f.luma_average   = '0;
        f.luma_valid     = 1'b0;
      end
      return f;
    endfunction

    function void note_pixel(in_data_t p);
      expected_features.insert(expected_features.size(), predict_features(p));
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %0d got %0d", name, exp_v, act_v);
      end
    endfunction

    function void check_beat(out_data_t d, logic valid_flag);
      feature_t e;
      if (expected_features.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", d);
        return;
      end
      e = expected_features.pop_front();
      compare_field("magnitude", 64'(e.magnitude), 64'(d.magnitude));
      compare_field("mean_all", 64'(e.mean_all), 64'(d.mean_all));
      compare_field("luma_perceived", 64'(e.luma_perceived), 64'(d.luma_perceived));
      compare_field("luma_relative", 64'(e.luma_relative), 64'(d.luma_relative));
      compare_field("luma_average", 64'(e.luma_average), 64'(d.luma_average));
      compare_field("luma_valid", 64'(e.luma_valid), 64'(valid_flag));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [NUM_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  feature_checker checker_h;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  pixel_luminance_magnitude_features u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) checker_h.check_beat(out_data_t'(out_tdata), out_tuser);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(in_data_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    checker_h.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_chan_count(logic [NUM_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    checker_h.set_chan_count(v);
  endtask

  function automatic logic [IN_FIELD_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return IN_FIELD_W'($urandom_range(0, 255));
      3: return 16'hFFFF - IN_FIELD_W'($urandom_range(0, 255));
      default: return IN_FIELD_W'($urandom);
    endcase
  endfunction

  function automatic in_data_t make_pixel(logic [15:0] c0, logic [15:0] c1,
                                          logic [15:0] c2, logic [15:0] c3);
    in_data_t p;
    p.chan_zero  = c0;
    p.chan_one   = c1;
    p.chan_two   = c2;
    p.chan_three = c3;
    return p;
  endfunction

  logic [NUM_W-1:0] dir_count [7]   = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd7};
  logic [NUM_W-1:0] phase_count [PHASES] =
    '{3'd1, 3'd4, 3'd2, 3'd3, 3'd6, 3'd0, 3'd4, 3'd1, 3'd3, 3'd2, 3'd7, 3'd5};
  in_data_t dir_pattern [7];

  initial begin
    in_data_t p;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    checker_h      = new();
    dir_pattern[0] = make_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    dir_pattern[1] = make_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    dir_pattern[2] = make_pixel(16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF);
    dir_pattern[3] = make_pixel(16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF);
    dir_pattern[4] = make_pixel(16'h0002, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    dir_pattern[5] = make_pixel(16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
    dir_pattern[6] = make_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0003);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count first, then counts 3, 2 and 1, then saturated values 0, 5 and 7
    for (int d = 0; d < 7; d++) begin
      if (d != 0) begin
        drain();
        write_chan_count(dir_count[d]);
      end
      send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_pixel(dir_pattern[d]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_chan_count(phase_count[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 6 && k == 40) drain();
        p = make_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
        send_pixel(p);
      end
    end

    in_tvalid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: pixel_luminance_magnitude_features.f
sv/pixlum_pkg.sv
sv/pixel_luminance_magnitude_features.sv
sv/pixlum_checker.sv
sim/tb_top.sv
